/* rtl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, fixed-point constants and types for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// hue fraction bits, 0..6 for a 15-bit hue
	localparam int HUE_FRAC_BITS = 6;

	localparam int HUE_W  = 15;
	localparam int CH_W   = 8;
	localparam int CH_MAX = 255;

	// one 60 degree sector and a full turn in hue units
	localparam int SPAN   = 60 * (2 ** HUE_FRAC_BITS);
	localparam int TURN   = 360 * (2 ** HUE_FRAC_BITS);
	localparam int REM_W  = $clog2(SPAN);
	localparam int SPAN_W = $clog2(SPAN + 1);

	// common denominator of q and t
	localparam int DEN    = CH_MAX * SPAN;
	localparam int DEN_W  = $clog2(DEN + 1);
	localparam int PROD_W = CH_W + DEN_W;

	// reciprocal of DEN, rounded up, scaled by 2^PROD_W
	localparam longint unsigned RECIP =
		((64'd1 << PROD_W) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int MUL_W   = PROD_W + RECIP_W;

	// quotient estimate, may be one too large
	localparam int QUO_W = CH_W + 1;

	typedef enum logic [2:0] {
		SECT_0 = 3'd0,
		SECT_1 = 3'd1,
		SECT_2 = 3'd2,
		SECT_3 = 3'd3,
		SECT_4 = 3'd4,
		SECT_5 = 3'd5
	} sector_t;

	// stage loads for the divider
	typedef struct packed {
		logic s4;
		logic s5;
	} div_en_t;

endpackage

/* rtl/hsv2rgb_div.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_div
// Two-stage exact division by DEN: reciprocal multiply, then back-multiply
// and a one-step correction.
// ----------------------------------------------------------------------------
module hsv2rgb_div (
	input  logic                            clk,
	input  hsv2rgb_pkg::div_en_t            en,
	input  logic [hsv2rgb_pkg::PROD_W-1:0]  dividend,
	output logic [hsv2rgb_pkg::CH_W-1:0]    quot
);

	logic [hsv2rgb_pkg::MUL_W-1:0]            recip_prod;
	logic [hsv2rgb_pkg::QUO_W-1:0]            est_s4;
	logic [hsv2rgb_pkg::PROD_W-1:0]           x_s4;
	logic [hsv2rgb_pkg::QUO_W+hsv2rgb_pkg::DEN_W-1:0] back_s5;
	logic [hsv2rgb_pkg::QUO_W-1:0]            est_s5;
	logic [hsv2rgb_pkg::PROD_W-1:0]           x_s5;
	logic [hsv2rgb_pkg::QUO_W-1:0]            fixed;

	assign recip_prod = hsv2rgb_pkg::MUL_W'(dividend)
		* hsv2rgb_pkg::MUL_W'(hsv2rgb_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			est_s4 <= hsv2rgb_pkg::QUO_W'(recip_prod >> hsv2rgb_pkg::PROD_W);
			x_s4   <= dividend;
		end
		if (en.s5) begin
			back_s5 <= (hsv2rgb_pkg::QUO_W + hsv2rgb_pkg::DEN_W)'(est_s4)
				* (hsv2rgb_pkg::QUO_W + hsv2rgb_pkg::DEN_W)'(hsv2rgb_pkg::DEN);
			est_s5  <= est_s4;
			x_s5    <= x_s4;
		end
	end

	// estimate is exact or one high
	always_comb begin
		if (back_s5 > (hsv2rgb_pkg::QUO_W + hsv2rgb_pkg::DEN_W)'(x_s5)) begin
			fixed = est_s5 - hsv2rgb_pkg::QUO_W'(1);
		end else begin
			fixed = est_s5;
		end
	end

	assign quot = fixed[hsv2rgb_pkg::CH_W-1:0];

endmodule

/* rtl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Streaming HSV to 8-bit RGB pixel converter, six pipeline stages.
// ----------------------------------------------------------------------------
// One pixel word in, one pixel word out. Hue is degrees scaled by
// 2^HUE_FRAC_BITS; hue of 360 degrees or more is taken as 0. Saturation and
// value are 8-bit fractions (255 = 1.0). Every channel is truncated once, at
// the end. The pipeline accepts a word every cycle while backpressure does not
// reach stage 1. The six stages are the sector split, the two multiply stages
// of the terms, the two stages of the reciprocal divider and the output
// routing.
// Backpressure collapses bubbles stage by stage, so words are never dropped or
// repeated while the output is stalled.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // hue[14:0], saturation[22:15], value[30:23], 0[31]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // red[7:0], green[15:8], blue[23:16]
);

	// input fields
	logic [hsv2rgb_pkg::HUE_W-1:0] in_hue;
	logic [hsv2rgb_pkg::CH_W-1:0]  in_sat;
	logic [hsv2rgb_pkg::CH_W-1:0]  in_val;

	assign in_hue = s_tdata[14:0];
	assign in_sat = s_tdata[22:15];
	assign in_val = s_tdata[30:23];

	// stage valids and readies
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !v_s6 || m_tready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: sector split by compares against sector boundaries
	// ------------------------------------------------------------------
	logic [31:0]                   hue_ext;
	logic                          hue_wrap;
	hsv2rgb_pkg::sector_t          sector_c;
	logic [31:0]                   base_c;
	logic [hsv2rgb_pkg::REM_W-1:0] rem_c;

	assign hue_ext  = 32'(in_hue);
	assign hue_wrap = hue_ext >= 32'(hsv2rgb_pkg::TURN);

	always_comb begin
		if (hue_wrap) begin
			sector_c = hsv2rgb_pkg::SECT_0;
			base_c   = hue_ext;  // remainder becomes zero
		end else if (hue_ext >= 32'(5 * hsv2rgb_pkg::SPAN)) begin
			sector_c = hsv2rgb_pkg::SECT_5;
			base_c   = 32'(5 * hsv2rgb_pkg::SPAN);
		end else if (hue_ext >= 32'(4 * hsv2rgb_pkg::SPAN)) begin
			sector_c = hsv2rgb_pkg::SECT_4;
			base_c   = 32'(4 * hsv2rgb_pkg::SPAN);
		end else if (hue_ext >= 32'(3 * hsv2rgb_pkg::SPAN)) begin
			sector_c = hsv2rgb_pkg::SECT_3;
			base_c   = 32'(3 * hsv2rgb_pkg::SPAN);
		end else if (hue_ext >= 32'(2 * hsv2rgb_pkg::SPAN)) begin
			sector_c = hsv2rgb_pkg::SECT_2;
			base_c   = 32'(2 * hsv2rgb_pkg::SPAN);
		end else if (hue_ext >= 32'(hsv2rgb_pkg::SPAN)) begin
			sector_c = hsv2rgb_pkg::SECT_1;
			base_c   = 32'(hsv2rgb_pkg::SPAN);
		end else begin
			sector_c = hsv2rgb_pkg::SECT_0;
			base_c   = 32'd0;
		end
	end

	assign rem_c = hsv2rgb_pkg::REM_W'(hue_ext - base_c);

	hsv2rgb_pkg::sector_t          sector_s1;
	logic [hsv2rgb_pkg::REM_W-1:0] rem_s1;
	logic [hsv2rgb_pkg::CH_W-1:0]  sat_s1;
	logic [hsv2rgb_pkg::CH_W-1:0]  val_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sector_s1 <= sector_c;
			rem_s1    <= rem_c;
			sat_s1    <= in_sat;
			val_s1    <= in_val;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: s*r, s*(span-r), v*(255-s); numerators of q and t
	// ------------------------------------------------------------------
	logic [hsv2rgb_pkg::SPAN_W-1:0]             rest_c;
	logic [hsv2rgb_pkg::CH_W+hsv2rgb_pkg::SPAN_W-1:0] sr_c;
	logic [hsv2rgb_pkg::CH_W+hsv2rgb_pkg::SPAN_W-1:0] sfr_c;

	assign rest_c = hsv2rgb_pkg::SPAN_W'(hsv2rgb_pkg::SPAN) - hsv2rgb_pkg::SPAN_W'(rem_s1);
	assign sr_c   = (hsv2rgb_pkg::CH_W + hsv2rgb_pkg::SPAN_W)'(sat_s1)
		* (hsv2rgb_pkg::CH_W + hsv2rgb_pkg::SPAN_W)'(rem_s1);
	assign sfr_c  = (hsv2rgb_pkg::CH_W + hsv2rgb_pkg::SPAN_W)'(sat_s1)
		* (hsv2rgb_pkg::CH_W + hsv2rgb_pkg::SPAN_W)'(rest_c);

	hsv2rgb_pkg::sector_t           sector_s2;
	logic [hsv2rgb_pkg::CH_W-1:0]   val_s2;
	logic [2*hsv2rgb_pkg::CH_W-1:0] pprod_s2;
	logic [hsv2rgb_pkg::DEN_W-1:0]  numq_s2;
	logic [hsv2rgb_pkg::DEN_W-1:0]  numt_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			pprod_s2  <= (2 * hsv2rgb_pkg::CH_W)'(val_s1)
				* (2 * hsv2rgb_pkg::CH_W)'(8'(hsv2rgb_pkg::CH_MAX) - sat_s1);
			numq_s2   <= hsv2rgb_pkg::DEN_W'(hsv2rgb_pkg::DEN) - hsv2rgb_pkg::DEN_W'(sr_c);
			numt_s2   <= hsv2rgb_pkg::DEN_W'(hsv2rgb_pkg::DEN) - hsv2rgb_pkg::DEN_W'(sfr_c);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: v*num for q and t; p = floor(pprod / 255)
	// ------------------------------------------------------------------
	logic [2*hsv2rgb_pkg::CH_W-1:0] p255_c;

	// exact for pprod up to 255 * 255: (x + (x >> 8) + 1) >> 8
	assign p255_c = pprod_s2 + (pprod_s2 >> hsv2rgb_pkg::CH_W)
		+ (2 * hsv2rgb_pkg::CH_W)'(1);

	hsv2rgb_pkg::sector_t           sector_s3;
	logic [hsv2rgb_pkg::CH_W-1:0]   val_s3;
	logic [hsv2rgb_pkg::CH_W-1:0]   p_s3;
	logic [hsv2rgb_pkg::PROD_W-1:0] xq_s3;
	logic [hsv2rgb_pkg::PROD_W-1:0] xt_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			p_s3      <= p255_c[2*hsv2rgb_pkg::CH_W-1:hsv2rgb_pkg::CH_W];
			xq_s3     <= hsv2rgb_pkg::PROD_W'(val_s2) * hsv2rgb_pkg::PROD_W'(numq_s2);
			xt_s3     <= hsv2rgb_pkg::PROD_W'(val_s2) * hsv2rgb_pkg::PROD_W'(numt_s2);
		end
	end

	// ------------------------------------------------------------------
	// Stages 4 and 5: divide both products by DEN
	// ------------------------------------------------------------------
	hsv2rgb_pkg::div_en_t         div_en;
	logic [hsv2rgb_pkg::CH_W-1:0] q_c;
	logic [hsv2rgb_pkg::CH_W-1:0] t_c;

	assign div_en.s4 = rdy_s4;
	assign div_en.s5 = rdy_s5;

	hsv2rgb_div u_div_q (
		.clk      (clk),
		.en       (div_en),
		.dividend (xq_s3),
		.quot     (q_c)
	);

	hsv2rgb_div u_div_t (
		.clk      (clk),
		.en       (div_en),
		.dividend (xt_s3),
		.quot     (t_c)
	);

	hsv2rgb_pkg::sector_t         sector_s4, sector_s5;
	logic [hsv2rgb_pkg::CH_W-1:0] val_s4, val_s5;
	logic [hsv2rgb_pkg::CH_W-1:0] p_s4, p_s5;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
			p_s4      <= p_s3;
		end
		if (rdy_s5) begin
			sector_s5 <= sector_s4;
			val_s5    <= val_s4;
			p_s5      <= p_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: route V, P, Q, T by sector into the output register
	// ------------------------------------------------------------------
	logic [hsv2rgb_pkg::CH_W-1:0] red_c, green_c, blue_c;

	always_comb begin
		case (sector_s5)
			hsv2rgb_pkg::SECT_0: begin
				red_c = val_s5; green_c = t_c;    blue_c = p_s5;
			end
			hsv2rgb_pkg::SECT_1: begin
				red_c = q_c;    green_c = val_s5; blue_c = p_s5;
			end
			hsv2rgb_pkg::SECT_2: begin
				red_c = p_s5;   green_c = val_s5; blue_c = t_c;
			end
			hsv2rgb_pkg::SECT_3: begin
				red_c = p_s5;   green_c = q_c;    blue_c = val_s5;
			end
			hsv2rgb_pkg::SECT_4: begin
				red_c = t_c;    green_c = p_s5;   blue_c = val_s5;
			end
			default: begin
				red_c = val_s5; green_c = p_s5;   blue_c = q_c;
			end
		endcase
	end

	logic [hsv2rgb_pkg::CH_W-1:0] red_s6, green_s6, blue_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			red_s6   <= red_c;
			green_s6 <= green_c;
			blue_s6  <= blue_c;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {blue_s6, green_s6, red_s6};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// corrected quotients never exceed the value they scale
	a_q_le_val: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (q_c <= val_s5))
		else $error("q term above value");

	a_t_le_val: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (t_c <= val_s5))
		else $error("t term above value");

	// input only stalls when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !m_tready))
		else $error("input stalled with a bubble in the pipeline");

endmodule

/* dv/hsv2rgb_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Watches both streams of the HSV to RGB converter, predicts each RGB pixel
// from the accepted HSV word and compares it with the delivered word.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // hue[14:0], saturation[22:15], value[30:23], 0[31]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // red[7:0], green[15:8], blue[23:16]
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_pixel_t;

	rgb_pixel_t expected_pixels[$];

	function automatic rgb_pixel_t convert_pixel(logic [14:0] hue, logic [7:0] sat,
			logic [7:0] val);
		longint unsigned h, s, v, span, den, rem, p, q, t;
		hsv2rgb_pkg::sector_t sect;
		rgb_pixel_t px;
		h    = hue;
		s    = sat;
		v    = val;
		span = hsv2rgb_pkg::SPAN;
		den  = 255 * span;
		if (s == 0) begin
			px.red   = val;
			px.green = val;
			px.blue  = val;
			return px;
		end
		// a full turn and anything beyond it fold to hue zero
		if (h >= hsv2rgb_pkg::TURN)
			h = 0;
		sect = hsv2rgb_pkg::sector_t'(3'(h / span));
		rem  = h % span;
		p = (v * (255 - s)) / 255;
		q = (v * (den - s * rem)) / den;
		t = (v * (den - s * (span - rem))) / den;
		case (sect)
			hsv2rgb_pkg::SECT_0: px = '{blue: p[7:0], green: t[7:0], red: val};
			hsv2rgb_pkg::SECT_1: px = '{blue: p[7:0], green: val,    red: q[7:0]};
			hsv2rgb_pkg::SECT_2: px = '{blue: t[7:0], green: val,    red: p[7:0]};
			hsv2rgb_pkg::SECT_3: px = '{blue: val,    green: q[7:0], red: p[7:0]};
			hsv2rgb_pkg::SECT_4: px = '{blue: val,    green: p[7:0], red: t[7:0]};
			default:             px = '{blue: q[7:0], green: p[7:0], red: val};
		endcase
		return px;
	endfunction

	always @(posedge clk) begin
		rgb_pixel_t got, want;
		if (arst_n) begin
			// output side first: a word can never leave in the cycle it arrives
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h, nothing pending", $time, m_tdata);
				end else begin
					want = expected_pixels.pop_front();
					if (got.red !== want.red) begin
						errors++;
						$display("%0t: red expected %h actual %h", $time, want.red, got.red);
					end
					if (got.green !== want.green) begin
						errors++;
						$display("%0t: green expected %h actual %h", $time, want.green,
							got.green);
					end
					if (got.blue !== want.blue) begin
						errors++;
						$display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_pixels.push_back(convert_pixel(s_tdata[14:0], s_tdata[22:15],
					s_tdata[30:23]));
		end
		pending = expected_pixels.size();
	end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the HSV to RGB converter: directed corner pixels,
// then random pixels in phases of source idling and sink backpressure.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 10000;
	localparam int ITEMS_PER_PHASE = 166;
	localparam int SETTLE_CYCLES = 20;   // pipeline is six deep

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // hue[14:0], saturation[22:15], value[30:23], 0[31]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // red[7:0], green[15:8], blue[23:16]

	int errors, pending;
	int source_idle_pct = 0;
	int sink_stall_pct = 0;
	int quiet_cycles = 0;

	// idle percentages per phase: none, source, sink, both, none
	int idle_plan[5]  = '{0, 76, 0, 28, 0};
	int stall_plan[5] = '{0, 0, 76, 28, 0};

	always #5 clk = ~clk;

	hsv_to_rgb_converter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	hsv2rgb_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// sink backpressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// stall watchdog: any word moving on either side clears it
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[hsv_to_rgb_converter] ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] hsv_word(int hue, int sat, int val);
		return {1'b0, 8'(val), 8'(sat), 15'(hue)};
	endfunction

	// one word, with random idle cycles ahead of it, held until taken
	task automatic send_word(logic [31:0] word);
		while ($urandom_range(99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// mostly in-range hue, with sector edges, the full turn and raw 15-bit noise
	function automatic int random_hue();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return $urandom_range(32767);
		else if (pick < 15)
			return hsv2rgb_pkg::TURN;
		else if (pick < 25)
			return hsv2rgb_pkg::SPAN * $urandom_range(5)
				+ ($urandom_range(1) ? 0 : hsv2rgb_pkg::SPAN - 1);
		else
			return $urandom_range(hsv2rgb_pkg::TURN - 1);
	endfunction

	function automatic int random_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return 0;
		else if (pick < 16)
			return 255;
		else
			return $urandom_range(255);
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// primaries and corners
		send_word(hsv_word(0, 255, 255));
		send_word(hsv_word(0, 0, 0));
		send_word(hsv_word(32767, 0, 200));        // grey ignores hue
		send_word(hsv_word(hsv2rgb_pkg::SPAN * 3, 0, 255));
		send_word(hsv_word(hsv2rgb_pkg::SPAN * 2, 255, 0));     // black
		send_word(hsv_word(hsv2rgb_pkg::SPAN, 1, 255));
		// middle and first third of every sector
		for (int k = 0; k < 6; k++)
			send_word(hsv_word(hsv2rgb_pkg::SPAN * k + hsv2rgb_pkg::SPAN / 2, 255, 255));
		for (int k = 0; k < 6; k++)
			send_word(hsv_word(hsv2rgb_pkg::SPAN * k + hsv2rgb_pkg::SPAN / 3, 170, 201));
		// sector edges, full turn and past it
		send_word(hsv_word(hsv2rgb_pkg::SPAN - 1, 255, 255));
		send_word(hsv_word(hsv2rgb_pkg::SPAN, 255, 255));
		send_word(hsv_word(hsv2rgb_pkg::TURN - 1, 255, 255));
		send_word(hsv_word(hsv2rgb_pkg::TURN, 200, 255));
		send_word(hsv_word(hsv2rgb_pkg::TURN + 1, 200, 255));
		send_word(hsv_word(32767, 255, 255));

		for (int ph = 0; ph < 5; ph++) begin
			source_idle_pct = idle_plan[ph];
			sink_stall_pct  = stall_plan[ph];
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_word(hsv_word(random_hue(), random_byte(), random_byte()));
		end
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("[hsv_to_rgb_converter] OK");
		else
			$display("[hsv_to_rgb_converter] ERROR");
		$finish;
	end

endmodule
